// ===== design/assert_macros.svh =====
// Assertion macros shared by the base64 decoder RTL.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Antecedent implies consequent on the same or a later edge (write |-> or |=>).
`define ASSERT_IMPLY(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPLY(lbl, clk, rstn, prop, msg)
`endif

`endif

// ===== design/b64d_pkg.sv =====
// Shared types and constants for the base64 decoder.
// No dependencies; used by all decoder modules.
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

    localparam logic [7:0] PAD_CHAR   = 8'h3D;  // '='
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;  // '+'
    localparam logic [7:0] SLASH_CHAR = 8'h2F;  // '/'

    localparam logic [31:0] INDEX_MAX = 32'hFFFF_FFFF;

    // Classified character as it travels from front to back.
    typedef struct packed {
        logic [7:0] chr;
        logic       last;
        logic       is_pad;
        logic       is_sym;   // inside the alphabet
        logic [5:0] sextet;
    } item_t;

endpackage

`default_nettype wire

// ===== design/base64_decoder.sv =====
// Base64 decoder top level: front classifier, queue and decoding back end.
// Depends on b64d_pkg, b64d_front, b64d_fifo and b64d_back.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one text character per transfer
//   in char_in, with last_char set on the final character of a text.
//   Output channel (out_valid/out_ready) carries at most one result per
//   character: a decoded byte (byte_valid), an error report (bad_input with
//   bad_position and bad_value), and/or end_of_text on the last character.
//   Characters that complete no byte and raise no error give no result.
//   Path: a result passes through the front register, a queue slot and the
//   result register. Throughput: one character per cycle while the receiver
//   takes results; the back end's decoding state update is combinational.
//   Receiver stall: the result register holds; the queue (FIFO_DEPTH
//   entries) and the front register keep taking characters until full, then
//   in_ready drops.
//   Reset: clears the front register, the queue, the result valid flag and
//   the decoding state; characters are accepted in the first cycle after reset.
//   After a last character the decoding state returns to its reset values.
`timescale 1ns / 1ps
`default_nettype none

module base64_decoder
#(
    parameter int FIFO_DEPTH = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  char_in,
    input  wire logic        last_char,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       data_byte,
    output logic             byte_valid,
    output logic             end_of_text,
    output logic             bad_input,
    output logic [31:0]      bad_position,
    output logic [7:0]       bad_value
);

    logic            q_push_valid;
    logic            q_push_ready;
    b64d_pkg::item_t q_push_data;
    logic            q_pop_valid;
    logic            q_pop_ready;
    b64d_pkg::item_t q_pop_data;

    b64d_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_in    (char_in),
        .last_char  (last_char),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data)
    );

    b64d_fifo
    #(
        .DEPTH (FIFO_DEPTH)
    )
    u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    b64d_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (q_pop_valid),
        .pop_ready    (q_pop_ready),
        .pop_data     (q_pop_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .data_byte    (data_byte),
        .byte_valid   (byte_valid),
        .end_of_text  (end_of_text),
        .bad_input    (bad_input),
        .bad_position (bad_position),
        .bad_value    (bad_value)
    );

endmodule

`default_nettype wire

// ===== design/b64d_front.sv =====
// Front end: accepts characters, maps them to 6-bit values and flags padding.
// Depends on b64d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64d_front
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [7:0]      char_in,
    input  wire logic            last_char,
    output logic                 push_valid,
    input  wire logic            push_ready,
    output b64d_pkg::item_t      push_data
);

    logic            front_valid_reg;
    logic            front_valid_next;
    b64d_pkg::item_t front_item_reg;
    b64d_pkg::item_t front_item_next;
    logic            take;

    always_comb
    begin
        front_item_next        = '0;
        front_item_next.chr    = char_in;
        front_item_next.last   = last_char;
        front_item_next.is_pad = (char_in == b64d_pkg::PAD_CHAR);
        if (char_in >= 8'h41 && char_in <= 8'h5A)
        begin
            front_item_next.is_sym = 1'b1;
            front_item_next.sextet = 6'(char_in - 8'h41);
        end
        else if (char_in >= 8'h61 && char_in <= 8'h7A)
        begin
            front_item_next.is_sym = 1'b1;
            front_item_next.sextet = 6'(char_in - 8'h61 + 8'd26);
        end
        else if (char_in >= 8'h30 && char_in <= 8'h39)
        begin
            front_item_next.is_sym = 1'b1;
            front_item_next.sextet = 6'(char_in - 8'h30 + 8'd52);
        end
        else if (char_in == b64d_pkg::PLUS_CHAR)
        begin
            front_item_next.is_sym = 1'b1;
            front_item_next.sextet = 6'd62;
        end
        else if (char_in == b64d_pkg::SLASH_CHAR)
        begin
            front_item_next.is_sym = 1'b1;
            front_item_next.sextet = 6'd63;
        end
    end

    assign in_ready         = !front_valid_reg || push_ready;
    assign take             = in_valid && in_ready;
    assign front_valid_next = take || (front_valid_reg && !push_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            front_item_reg <= front_item_next;
        end
    end

    assign push_valid = front_valid_reg;
    assign push_data  = front_item_reg;

endmodule

`default_nettype wire

// ===== design/b64d_fifo.sv =====
// Short queue of classified characters between front and back.
// Depends on b64d_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module b64d_fifo
#(
    parameter int DEPTH = 2
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire b64d_pkg::item_t push_data,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output b64d_pkg::item_t      pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64d_pkg::item_t    slots [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    `ASSERT_ALWAYS(a_count_range, clk, rst_n, count_reg <= CNT_W'(DEPTH), "queue count overflow")
    `ASSERT_IMPLY(a_ptr_gap, clk, rst_n, (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg), "empty queue with pointer gap")

endmodule

`default_nettype wire

// ===== design/b64d_back.sv =====
// Back end: decoding state (bit store, group phase, padding, error, index)
// and the result register. Depends on b64d_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module b64d_back
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            pop_valid,
    output logic                 pop_ready,
    input  wire b64d_pkg::item_t pop_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [7:0]           data_byte,
    output logic                 byte_valid,
    output logic                 end_of_text,
    output logic                 bad_input,
    output logic [31:0]          bad_position,
    output logic [7:0]           bad_value
);

    logic [5:0]  store_reg, store_next;
    logic [1:0]  phase_reg, phase_next;
    logic        pad_reg, pad_next;
    logic        err_reg, err_next;
    logic [31:0] index_reg, index_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  data_reg, data_next;
    logic        bvalid_reg, bvalid_next;
    logic        eot_reg, eot_next;
    logic        bad_reg, bad_next;
    logic [31:0] bpos_reg, bpos_next;
    logic [7:0]  bval_reg, bval_next;

    logic        take;
    logic        emit;
    logic [5:0]  s;

    assign pop_ready = !out_valid_reg || out_ready;
    assign take      = pop_valid && pop_ready;
    assign s         = pop_data.sextet;

    always_comb
    begin
        store_next  = store_reg;
        phase_next  = phase_reg;
        pad_next    = pad_reg;
        err_next    = err_reg;
        index_next  = index_reg;
        emit        = 1'b0;
        data_next   = '0;
        bvalid_next = 1'b0;
        eot_next    = 1'b0;
        bad_next    = 1'b0;
        bpos_next   = '0;
        bval_next   = '0;

        if (!err_reg)
        begin
            if (pop_data.is_pad)
            begin
                pad_next = 1'b1;
            end
            else if (!pop_data.is_sym || pad_reg)
            begin
                err_next  = 1'b1;
                bad_next  = 1'b1;
                bpos_next = index_reg;
                bval_next = pop_data.chr;
                emit      = 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    2'd0:
                    begin
                        store_next = s;
                    end
                    2'd1:
                    begin
                        data_next   = {store_reg, s[5:4]};
                        store_next  = {2'b00, s[3:0]};
                        bvalid_next = 1'b1;
                    end
                    2'd2:
                    begin
                        data_next   = {store_reg[3:0], s[5:2]};
                        store_next  = {4'b0000, s[1:0]};
                        bvalid_next = 1'b1;
                    end
                    default:
                    begin
                        data_next   = {store_reg[1:0], s};
                        store_next  = '0;
                        bvalid_next = 1'b1;
                    end
                endcase
                phase_next = phase_reg + 1'b1;
                emit       = bvalid_next;
            end
            if (!err_next && index_reg != b64d_pkg::INDEX_MAX)
            begin
                index_next = index_reg + 1'b1;
            end
        end

        if (pop_data.last)
        begin
            eot_next   = 1'b1;
            emit       = 1'b1;
            store_next = '0;
            phase_next = '0;
            pad_next   = 1'b0;
            err_next   = 1'b0;
            index_next = '0;
        end

        out_valid_next = out_valid_reg && !out_ready;
        if (take && emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg     <= '0;
            phase_reg     <= '0;
            pad_reg       <= 1'b0;
            err_reg       <= 1'b0;
            index_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                store_reg <= store_next;
                phase_reg <= phase_next;
                pad_reg   <= pad_next;
                err_reg   <= err_next;
                index_reg <= index_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            data_reg   <= data_next;
            bvalid_reg <= bvalid_next;
            eot_reg    <= eot_next;
            bad_reg    <= bad_next;
            bpos_reg   <= bpos_next;
            bval_reg   <= bval_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign data_byte    = data_reg;
    assign byte_valid   = bvalid_reg;
    assign end_of_text  = eot_reg;
    assign bad_input    = bad_reg;
    assign bad_position = bpos_reg;
    assign bad_value    = bval_reg;

    `ASSERT_IMPLY(a_last_clears, clk, rst_n, (take && pop_data.last) |=> (phase_reg == 2'd0 && !err_reg && !pad_reg && index_reg == '0), "state not cleared after last character")
    `ASSERT_ALWAYS(a_byte_xor_bad, clk, rst_n, !(out_valid_reg && bvalid_reg && bad_reg), "byte and error in one result")

endmodule

`default_nettype wire
